### sv/css_pkg.sv
// Shared types and codes for the collective step schedule block.
package css_pkg;

    // Collective algorithm selected by the mode register.
    typedef enum logic [1:0] {
        MODE_RING_ALLGATHER = 2'd0,
        MODE_RING_REDSCAT   = 2'd1,
        MODE_RING_ALLREDUCE = 2'd2,
        MODE_HD_ALLREDUCE   = 2'd3
    } css_mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_LOCAL_RANK  = 2'd0,
        REG_GROUP_SIZE  = 2'd1,
        REG_CHUNK_BYTES = 2'd2,
        REG_MODE        = 2'd3
    } css_reg_t;

    // How the back end forms the byte count of a step.
    typedef enum logic [1:0] {
        BYTES_NONE    = 2'd0,
        BYTES_CHUNK   = 2'd1,
        BYTES_SHIFTED = 2'd2
    } css_bytes_t;

    localparam int unsigned RANK_W  = 10;
    localparam int unsigned GROUP_W = 11;
    localparam int unsigned CHUNK_W = 32;
    localparam int unsigned STEP_W  = 11;
    localparam int unsigned BYTES_W = 42;
    localparam int unsigned PROD_W  = CHUNK_W + GROUP_W;
    localparam int unsigned SHIFT_W = 4;

    // Configuration as seen by the front and back ends.
    typedef struct packed {
        logic [RANK_W-1:0]  local_rank;
        logic [GROUP_W-1:0] group_size;   // already limited to the rank capacity
        logic [CHUNK_W-1:0] chunk_bytes;
        css_mode_t          mode;
    } css_setup_t;

    // Classified step, queued between the front and the back end.
    typedef struct packed {
        logic              recv_valid;
        logic [RANK_W-1:0] recv_peer;
        logic              send_valid;
        logic [RANK_W-1:0] send_peer;
        css_bytes_t        bytes_kind;
        logic [SHIFT_W-1:0] bytes_shift;
        logic              final_step;
        logic              out_of_range;
    } css_entry_t;

endpackage

### sv/collective_step_schedule.sv
// A request passes through the queue and the back-end registers s1 and s2
// before its result is presented. One request per cycle while the output is not
// stalled; the chunk-times-group multiply is registered in s1, ahead of the s2 output.
// Reset (synchronous, active low) restores the registers to rank 0, group
// size 2, chunk 0, ring allgather, and empties the queue and the back end.
// There is no stored table, so no clearing pass follows reset.
module collective_step_schedule #(
    parameter int unsigned MAX_RANKS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [10:0] step_index, [15:11] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [0] recv_valid, [10:1] recv_peer,
                                     // [11] send_valid, [21:12] send_peer,
                                     // [63:22] byte_count
    output logic        m_tlast,     // final_step
    output logic [0:0]  m_tuser      // [0] out_of_range
);

    // Configuration registers. The user must change them only while the block is idle
    // (the block itself does not enforce this), and both ends read them directly.
    logic [9:0]          local_rank_reg;
    logic [10:0]         group_size_reg;
    logic [31:0]         chunk_bytes_reg;
    css_pkg::css_mode_t  mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_rank_reg  <= 10'd0;
            group_size_reg  <= 11'd2;
            chunk_bytes_reg <= 32'd0;
            mode_reg        <= css_pkg::MODE_RING_ALLGATHER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                css_pkg::REG_LOCAL_RANK:  local_rank_reg  <= cfg_wr_data[9:0];
                css_pkg::REG_GROUP_SIZE:  group_size_reg  <= cfg_wr_data[10:0];
                css_pkg::REG_CHUNK_BYTES: chunk_bytes_reg <= cfg_wr_data;
                css_pkg::REG_MODE:        mode_reg <= css_pkg::css_mode_t'(cfg_wr_data[1:0]);
                default: ;
            endcase
        end
    end

    // A group size beyond the rank capacity is treated as the capacity.
    css_pkg::css_setup_t setup;
    logic                too_big;

    assign too_big = ({5'd0, group_size_reg} > 16'(MAX_RANKS));

    always_comb begin
        setup.local_rank  = local_rank_reg;
        setup.group_size  = too_big ? 11'(MAX_RANKS) : group_size_reg;
        setup.chunk_bytes = chunk_bytes_reg;
        setup.mode        = mode_reg;
    end

    // Front end: classify the step as soon as the request arrives.
    css_pkg::css_entry_t front_entry;

    css_front u_front (
        .setup      (setup),
        .step_index (s_tdata[10:0]),
        .entry      (front_entry)
    );

    // Short queue so that a stalled output does not stop request intake at once.
    logic                q_valid;
    logic                q_ready;
    css_pkg::css_entry_t q_entry;

    css_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_entry  (front_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    // Back end: byte count and the output register.
    css_pkg::css_entry_t out_entry;
    logic [41:0]         out_bytes;

    css_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .setup     (setup),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_entry  (q_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry),
        .out_bytes (out_bytes)
    );

    // Pack the result. Peers and the byte count are already zero in steps
    // that do not use them.
    assign m_tdata = {out_bytes,
                      out_entry.send_peer,
                      out_entry.send_valid,
                      out_entry.recv_peer,
                      out_entry.recv_valid};
    assign m_tlast = out_entry.final_step;
    assign m_tuser = out_entry.out_of_range;

endmodule

### sv/css_front.sv
// Front end: classifies a step query into peers, flags and a byte-count recipe.
module css_front (
    input  css_pkg::css_setup_t           setup,
    input  logic [css_pkg::STEP_W-1:0]    step_index,
    output css_pkg::css_entry_t           entry
);

    logic [3:0]  lg;
    logic [10:0] pw;
    logic [10:0] r;
    logic [10:0] twor;
    logic        has_align;
    logic [10:0] p;
    logic [10:0] rank11;
    logic        grp_ok;
    logic [11:0] len;
    logic [11:0] step12;
    logic        oor;
    logic [10:0] ring_rp;
    logic [10:0] ring_sp;
    logic        low;
    logic [9:0]  mate;
    logic [4:0]  k;
    logic [4:0]  j5;
    logic [4:0]  lg5;
    logic [4:0]  e5;
    logic [3:0]  e;
    logic [10:0] nr;
    logic [10:0] nn;
    logic [10:0] hd_peer;

    assign p      = setup.group_size;
    assign rank11 = {1'b0, setup.local_rank};
    assign step12 = {1'b0, step_index};

    // Highest set bit of the group size gives log2 of the power-of-two core.
    always_comb begin
        lg = '0;
        for (int i = 0; i < 11; i++) begin
            if (p[i]) begin
                lg = 4'(i);
            end
        end
    end

    assign pw        = 11'd1 << lg;
    assign r         = p - pw;
    assign has_align = (r != 11'd0);
    assign twor      = {r[9:0], 1'b0};
    assign grp_ok    = (p >= 11'd2) && (rank11 < p);

    always_comb begin
        unique case (setup.mode)
            css_pkg::MODE_HD_ALLREDUCE:
                len = 12'({lg, 1'b0}) + (has_align ? 12'd3 : 12'd0);
            css_pkg::MODE_RING_ALLREDUCE:
                len = {p, 1'b0} - 12'd2;
            css_pkg::MODE_RING_ALLGATHER,
            css_pkg::MODE_RING_REDSCAT:
                len = {1'b0, p} - 12'd1;
            default:
                len = '0;
        endcase
        if (!grp_ok) begin
            len = '0;
        end
    end

    assign oor = (step12 >= len);

    // Ring neighbors, wrapping around the group.
    assign ring_rp = (rank11 == 11'd0) ? (p - 11'd1) : (rank11 - 11'd1);
    assign ring_sp = ((rank11 + 11'd1) == p) ? 11'd0 : (rank11 + 11'd1);

    // Halving-doubling: partner lookup on the renumbered power-of-two core.
    assign low  = (rank11 < twor);
    assign mate = setup.local_rank ^ 10'd1;
    assign k    = step_index[4:0];
    assign j5   = has_align ? (k - 5'd2) : k;
    assign lg5  = {1'b0, lg};
    assign e5   = (j5 < lg5) ? j5 : ({lg5[3:0], 1'b0} - 5'd1 - j5);
    assign e    = e5[3:0];
    assign nr   = low ? {2'b00, setup.local_rank[9:1]} : (rank11 - r);
    assign nn   = nr ^ (11'd1 << e);
    assign hd_peer = (nn < r) ? {nn[9:0], 1'b0} : (nn + r);

    always_comb begin
        entry = '0;
        entry.bytes_kind = css_pkg::BYTES_NONE;
        priority if (oor) begin
            entry.out_of_range = 1'b1;
        end else if (setup.mode != css_pkg::MODE_HD_ALLREDUCE) begin
            entry.recv_valid = 1'b1;
            entry.recv_peer  = ring_rp[9:0];
            entry.send_valid = 1'b1;
            entry.send_peer  = ring_sp[9:0];
            entry.bytes_kind = css_pkg::BYTES_CHUNK;
        end else if (has_align && (k < 5'd2)) begin
            // Fold-in: paired extra ranks swap halves, then the odd rank hands its half to the even neighbor.
            if (low) begin
                if (k == 5'd0) begin
                    entry.recv_valid  = 1'b1;
                    entry.recv_peer   = mate;
                    entry.send_valid  = 1'b1;
                    entry.send_peer   = mate;
                    entry.bytes_kind  = css_pkg::BYTES_SHIFTED;
                    entry.bytes_shift = 4'd1;
                end else if (setup.local_rank[0]) begin
                    entry.send_valid  = 1'b1;
                    entry.send_peer   = mate;
                    entry.bytes_kind  = css_pkg::BYTES_SHIFTED;
                    entry.bytes_shift = 4'd1;
                end else begin
                    entry.recv_valid = 1'b1;
                    entry.recv_peer  = mate;
                end
            end
        end else if (has_align && (step12 == (len - 12'd1))) begin
            // Fold-out: even ranks return the full result to the odd neighbor.
            if (low) begin
                if (setup.local_rank[0]) begin
                    entry.recv_valid = 1'b1;
                    entry.recv_peer  = mate;
                end else begin
                    entry.send_valid  = 1'b1;
                    entry.send_peer   = mate;
                    entry.bytes_kind  = css_pkg::BYTES_SHIFTED;
                    entry.bytes_shift = 4'd0;
                end
            end
        end else begin
            if (!low || !setup.local_rank[0]) begin
                entry.recv_valid  = 1'b1;
                entry.recv_peer   = hd_peer[9:0];
                entry.send_valid  = 1'b1;
                entry.send_peer   = hd_peer[9:0];
                entry.bytes_kind  = css_pkg::BYTES_SHIFTED;
                entry.bytes_shift = e + 4'd1;
            end
        end
        if (!oor) begin
            entry.final_step = (step12 == (len - 12'd1));
        end
    end

endmodule

### sv/css_queue.sv
// Two-entry queue that decouples the front end from the back end.
module css_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  css_pkg::css_entry_t in_entry,
    output logic                out_valid,
    input  logic                out_ready,
    output css_pkg::css_entry_t out_entry
);

    css_pkg::css_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

### sv/css_back.sv
// Back end: forms the byte count (the chunk, or the product shifted) and holds the result.
module css_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  css_pkg::css_setup_t           setup,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  css_pkg::css_entry_t           in_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output css_pkg::css_entry_t           out_entry,
    output logic [css_pkg::BYTES_W-1:0]   out_bytes
);

    logic                              s1_valid_reg, s1_valid_next;
    css_pkg::css_entry_t               s1_entry_reg;
    logic [css_pkg::PROD_W-1:0]        s1_prod_reg;
    logic                              s2_valid_reg, s2_valid_next;
    css_pkg::css_entry_t               s2_entry_reg;
    logic [css_pkg::BYTES_W-1:0]       s2_bytes_reg, s2_bytes_next;
    logic [css_pkg::PROD_W-1:0]        prod_next;
    logic [css_pkg::PROD_W-1:0]        shifted;
    logic                              s2_ready;
    logic                              s1_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Whole-message size c*p; the shift picks its share for the step.
    assign prod_next = css_pkg::PROD_W'(setup.chunk_bytes)
                     * css_pkg::PROD_W'(setup.group_size);
    assign shifted   = s1_prod_reg >> s1_entry_reg.bytes_shift;

    always_comb begin
        unique case (s1_entry_reg.bytes_kind)
            css_pkg::BYTES_CHUNK:
                s2_bytes_next = css_pkg::BYTES_W'(setup.chunk_bytes);
            css_pkg::BYTES_SHIFTED:
                s2_bytes_next = shifted[css_pkg::BYTES_W-1:0];
            default:
                s2_bytes_next = '0;
        endcase
    end

    always_comb begin
        s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_entry_reg <= in_entry;
            s1_prod_reg  <= prod_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_entry_reg <= s1_entry_reg;
            s2_bytes_reg <= s2_bytes_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_entry = s2_entry_reg;
    assign out_bytes = s2_bytes_reg;

endmodule
